/* rtl/core/aes_pkg.sv */
package aes_pkg;

  localparam int unsigned Rounds = 14;
  localparam int unsigned KeyRegs = 4;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] blk_t;

  typedef enum logic [1:0] {
    CFG_KEY_WORD_0 = 2'd0,
    CFG_KEY_WORD_1 = 2'd1,
    CFG_KEY_WORD_2 = 2'd2,
    CFG_KEY_WORD_3 = 2'd3
  } cfg_idx_e;

  // control from the key expander to the cipher core
  typedef struct packed {
    logic busy;
  } ks_status_t;

  function automatic byte_t xtime(byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic byte_t gf_mul(byte_t a, byte_t b);
    byte_t acc;
    byte_t x;
    acc = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc = acc ^ x;
      x = xtime(x);
    end
    gf_mul = acc;
  endfunction

  function automatic byte_t sbox(byte_t x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic byte_t inv_sbox(byte_t x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

endpackage

/* rtl/core/aes_key_expand.sv */
// Expands the key into the round-key memory, one 128-bit round key per cycle
// (four schedule words, a full half-key, per cycle) unless go_i restarts it.
module aes_key_expand #(
  parameter int unsigned ROUNDS = aes_pkg::Rounds,
  localparam int unsigned AW = $clog2(ROUNDS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic [255:0]       key_i,
  output logic               we_o,
  output logic [AW-1:0]      waddr_o,
  output logic [127:0]       wdata_o,
  output aes_pkg::ks_status_t status_o
);

  typedef enum logic {KS_IDLE, KS_RUN} ks_state_e;

  ks_state_e       state_q;
  logic [127:0]    prev2_q, prev1_q;   // round keys i-2 and i-1
  logic [AW-1:0]   idx_q;
  logic [7:0]      rcon_q;
  logic [127:0]    next_key;

  function automatic logic [31:0] sub_word(logic [31:0] w);
    sub_word = {aes_pkg::sbox(w[31:24]), aes_pkg::sbox(w[23:16]),
                aes_pkg::sbox(w[15:8]), aes_pkg::sbox(w[7:0])};
  endfunction

  always_comb begin
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    if (!idx_q[0]) begin
      t = sub_word({prev1_q[23:0], prev1_q[31:24]}) ^ {rcon_q, 24'h0};
    end else begin
      t = sub_word(prev1_q[31:0]);
    end
    w0 = prev2_q[127:96] ^ t;
    w1 = prev2_q[95:64] ^ w0;
    w2 = prev2_q[63:32] ^ w1;
    w3 = prev2_q[31:0] ^ w2;
    next_key = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KS_RUN;
      idx_q   <= '0;
      rcon_q  <= 8'h01;
      prev2_q <= '0;
      prev1_q <= '0;
    end else begin
      case (state_q)
        KS_IDLE: begin
          if (go_i) begin
            state_q <= KS_RUN;
            idx_q   <= '0;
            rcon_q  <= 8'h01;
          end
        end
        KS_RUN: begin
          if (go_i) begin
            idx_q  <= '0;
            rcon_q <= 8'h01;
          end else begin
            if (idx_q >= AW'(2)) begin
              prev2_q <= prev1_q;
              prev1_q <= next_key;
              if (!idx_q[0]) rcon_q <= aes_pkg::xtime(rcon_q);
            end else if (idx_q == AW'(0)) begin
              prev2_q <= key_i[255:128];
            end else begin
              prev1_q <= key_i[127:0];
            end
            if (idx_q == AW'(ROUNDS)) state_q <= KS_IDLE;
            idx_q <= idx_q + AW'(1);
          end
        end
        default: state_q <= KS_IDLE;
      endcase
    end
  end

  always_comb begin
    we_o    = (state_q == KS_RUN) && !go_i;
    waddr_o = idx_q;
    case (idx_q)
      AW'(0):  wdata_o = key_i[255:128];
      AW'(1):  wdata_o = key_i[127:0];
      default: wdata_o = next_key;
    endcase
    status_o.busy = (state_q == KS_RUN) || go_i;
  end

endmodule

/* rtl/core/aes_round_core.sv */
// One round per cycle; each round key is read ahead from memory into rk_q.
module aes_round_core #(
  parameter int unsigned ROUNDS = aes_pkg::Rounds,
  localparam int unsigned AW = $clog2(ROUNDS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                kind_i,
  input  logic [127:0]        block_i,
  input  aes_pkg::ks_status_t ks_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [127:0]        wdata_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [127:0]        result_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_FIRST, ST_ROUND} st_e;

  logic [127:0]  mem_q [ROUNDS+1];
  logic [127:0]  rk_q;
  logic [AW-1:0] raddr, rnd_q;
  st_e           state_q;
  logic          kind_q, done_q;
  logic [127:0]  st_q, round_out;

  // next read address: key for the round after the one done this cycle
  always_comb begin
    if (state_q == ST_IDLE) begin
      raddr = start_i ? (kind_i ? AW'(ROUNDS) : AW'(0)) : AW'(0);
    end else begin
      raddr = kind_q ? rnd_q - AW'(1) : rnd_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rk_q <= mem_q[raddr];
  end

  function automatic aes_pkg::byte_t gb(logic [127:0] s, int i);
    gb = s[127-8*i -: 8];
  endfunction

  always_comb begin
    logic [7:0] a [16];
    logic [7:0] b [16];
    logic [7:0] m [16];
    logic last;
    last = kind_q ? (rnd_q == AW'(0)) : (rnd_q == AW'(ROUNDS));
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (!kind_q) a[c*4+r] = aes_pkg::sbox(gb(st_q, ((c + r) % 4) * 4 + r));
        else a[((c + r) % 4) * 4 + r] = aes_pkg::inv_sbox(gb(st_q, c*4+r));
      end
    end
    if (kind_q) begin
      for (int i = 0; i < 16; i++) a[i] = a[i] ^ gb(rk_q, i);
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        if (!kind_q) begin
          m[c*4+j] = aes_pkg::gf_mul(a[c*4+j], 8'd2) ^ aes_pkg::gf_mul(a[c*4+(j+1)%4], 8'd3)
                     ^ a[c*4+(j+2)%4] ^ a[c*4+(j+3)%4];
        end else begin
          m[c*4+j] = aes_pkg::gf_mul(a[c*4+j], 8'd14) ^ aes_pkg::gf_mul(a[c*4+(j+1)%4], 8'd11)
                     ^ aes_pkg::gf_mul(a[c*4+(j+2)%4], 8'd13)
                     ^ aes_pkg::gf_mul(a[c*4+(j+3)%4], 8'd9);
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (last) b[i] = kind_q ? a[i] : a[i] ^ gb(rk_q, i);
      else b[i] = kind_q ? m[i] : m[i] ^ gb(rk_q, i);
    end
    for (int i = 0; i < 16; i++) round_out[127-8*i -: 8] = b[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      rnd_q   <= '0;
      kind_q  <= 1'b0;
      st_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i && !ks_i.busy) begin
            state_q <= ST_FIRST;
            kind_q  <= kind_i;
            st_q    <= block_i;
            rnd_q   <= kind_i ? AW'(ROUNDS) : AW'(0);
          end
        end
        ST_FIRST: begin
          st_q    <= st_q ^ rk_q;
          rnd_q   <= kind_q ? rnd_q - AW'(1) : rnd_q + AW'(1);
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          st_q <= round_out;
          if (kind_q ? (rnd_q == AW'(0)) : (rnd_q == AW'(ROUNDS))) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end else begin
            rnd_q <= kind_q ? rnd_q - AW'(1) : rnd_q + AW'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != ST_IDLE) || ks_i.busy;
  assign done_o   = done_q;
  assign result_o = st_q;

endmodule

/* rtl/core/aes256_block_cipher.sv */
// A block is accepted when start_i is high and busy_o is low; a new block is accepted
// only once the previous one is done, as there is a single round unit and key memory port.
// done_o is high for a single cycle with the result; the receiver cannot stall.
// Reset and every key write start a key expansion that writes ROUNDS+1 round keys,
// one round key per cycle into the memory unless a key write restarts it; busy_o stays high meanwhile.
module aes256_block_cipher #(
  parameter int unsigned ROUNDS = aes_pkg::Rounds,
  localparam int unsigned AW = $clog2(ROUNDS + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        kind_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        done_o,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0]         key_q [aes_pkg::KeyRegs];
  logic                go;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [127:0]        wdata, res;
  aes_pkg::ks_status_t ks;

  assign cfg_ready_o = 1'b1;
  assign go = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < aes_pkg::KeyRegs; i++) key_q[i] <= '0;
    end else if (cfg_valid_i) begin
      case (aes_pkg::cfg_idx_e'(cfg_index_i))
        aes_pkg::CFG_KEY_WORD_0: key_q[0] <= cfg_data_i;
        aes_pkg::CFG_KEY_WORD_1: key_q[1] <= cfg_data_i;
        aes_pkg::CFG_KEY_WORD_2: key_q[2] <= cfg_data_i;
        aes_pkg::CFG_KEY_WORD_3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aes_key_expand #(.ROUNDS(ROUNDS)) u_ks (
    .clk_i, .rst_ni, .go_i(go),
    .key_i({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .status_o(ks)
  );

  aes_round_core #(.ROUNDS(ROUNDS)) u_core (
    .clk_i, .rst_ni, .start_i, .kind_i,
    .block_i({block_high_i, block_low_i}), .ks_i(ks),
    .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .busy_o, .done_o, .result_o(res)
  );

  assign result_high_o = res[127:64];
  assign result_low_o  = res[63:0];

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic        kind;
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_req_t;

  localparam int unsigned NumPhases = 8;
  localparam int unsigned PerPhase = 250;
  localparam int unsigned CycleLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        kind_i;
  logic [63:0] block_high_i;
  logic [63:0] block_low_i;
  logic        done_o;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  aes256_block_cipher dut (.*);

  blk_req_t     pending_blocks[$];
  logic [127:0] cipher_results[$];
  logic [7:0]   fwd_sub[256];
  logic [7:0]   inv_sub[256];
  logic [63:0]  key_regs[4];
  logic [127:0] round_keys[15];
  int unsigned  fail_cnt;
  int unsigned  cycle_cnt;
  int unsigned  gap;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1B) : {a[6:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic void build_sub();
    logic [7:0] inv, base, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      base = x[7:0];
      for (int i = 0; i < 8; i++) begin
        if ((254 >> i) & 1) inv = gmul(inv, base);
        base = gmul(base, base);
      end
      if (x == 0) inv = 8'h00;
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sub[x] = s;
      inv_sub[s] = x[7:0];
    end
  endfunction

  function automatic void expand_keys();
    logic [7:0] w[60][4];
    logic [7:0] t[4];
    logic [7:0] f;
    logic [7:0] rcon;
    rcon = 8'h01;
    for (int b = 0; b < 32; b++)
      w[b / 4][b % 4] = key_regs[b / 8][63 - 8 * (b % 8) -: 8];
    for (int i = 8; i < 60; i++) begin
      t = w[i - 1];
      if (i % 8 == 0) begin
        f = t[0];
        t[0] = fwd_sub[t[1]] ^ rcon;
        t[1] = fwd_sub[t[2]];
        t[2] = fwd_sub[t[3]];
        t[3] = fwd_sub[f];
        rcon = gmul(rcon, 8'h02);
      end else if (i % 8 == 4) begin
        for (int j = 0; j < 4; j++) t[j] = fwd_sub[t[j]];
      end
      for (int j = 0; j < 4; j++) w[i][j] = w[i - 8][j] ^ t[j];
    end
    for (int r = 0; r < 15; r++)
      for (int b = 0; b < 16; b++)
        round_keys[r][127 - 8 * b -: 8] = w[r * 4 + b / 4][b % 4];
  endfunction

  // byte at row r, column c sits at index c*4+r
  function automatic logic [127:0] aes_block(logic kind, logic [127:0] blk);
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [127:0] res;
    logic [7:0] fm[4];
    logic [7:0] im[4];
    logic [7:0] col[4];
    fm = '{8'd2, 8'd3, 8'd1, 8'd1};
    im = '{8'd14, 8'd11, 8'd13, 8'd9};
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
    for (int step = 0; step <= 14; step++) begin
      int r;
      r = kind ? 14 - step : step;
      if (step != 0) begin
        t = s;
        for (int c = 0; c < 4; c++)
          for (int rw = 0; rw < 4; rw++)
            if (kind) s[((c + rw) % 4) * 4 + rw] = inv_sub[t[c * 4 + rw]];
            else s[c * 4 + rw] = fwd_sub[t[((c + rw) % 4) * 4 + rw]];
      end
      // forward: MixColumns before AddRoundKey; inverse: after it
      if (!kind && step != 0 && step != 14) begin
        for (int c = 0; c < 4; c++) begin
          for (int j = 0; j < 4; j++) begin
            col[j] = 8'h00;
            for (int k = 0; k < 4; k++) col[j] ^= gmul(s[c * 4 + k], fm[(k - j + 4) % 4]);
          end
          for (int j = 0; j < 4; j++) s[c * 4 + j] = col[j];
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= round_keys[r][127 - 8 * i -: 8];
      if (kind && step != 0 && step != 14) begin
        for (int c = 0; c < 4; c++) begin
          for (int j = 0; j < 4; j++) begin
            col[j] = 8'h00;
            for (int k = 0; k < 4; k++) col[j] ^= gmul(s[c * 4 + k], im[(k - j + 4) % 4]);
          end
          for (int j = 0; j < 4; j++) s[c * 4 + j] = col[j];
        end
      end
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
    return res;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // driver: one transaction per start_i/!busy_o edge, random gap per item
  always @(posedge clk_i or negedge rst_ni) begin
    blk_req_t req;
    if (!rst_ni) begin
      start_i <= 1'b0;
      kind_i <= 1'b0;
      block_high_i <= '0;
      block_low_i <= '0;
      gap = 0;
    end else if (!(start_i && busy_o)) begin
      if (start_i)
        cipher_results.push_back(aes_block(kind_i, {block_high_i, block_low_i}));
      if (gap != 0) begin
        start_i <= 1'b0;
        gap--;
      end else if (pending_blocks.size() != 0) begin
        req = pending_blocks.pop_front();
        start_i <= 1'b1;
        kind_i <= req.kind;
        block_high_i <= req.hi;
        block_low_i <= req.lo;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [127:0] exp_blk;
    if (rst_ni && done_o) begin
      if (cipher_results.size() == 0) begin
        $display("%0t: unexpected result %h_%h", $time, result_high_o, result_low_o);
        fail_cnt++;
      end else begin
        exp_blk = cipher_results.pop_front();
        if (result_high_o !== exp_blk[127:64]) begin
          $display("%0t: result_high expected %h actual %h", $time, exp_blk[127:64],
                   result_high_o);
          fail_cnt++;
        end
        if (result_low_o !== exp_blk[63:0]) begin
          $display("%0t: result_low expected %h actual %h", $time, exp_blk[63:0],
                   result_low_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL aes256_block_cipher");
      $finish;
    end
  end

  task automatic write_key(int idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= aes_pkg::cfg_idx_e'(idx);
    cfg_data_i <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    key_regs[idx] = data;
    expand_keys();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_block(logic kind, logic [63:0] hi, logic [63:0] lo);
    blk_req_t req;
    req.kind = kind;
    req.hi = hi;
    req.lo = lo;
    pending_blocks.push_back(req);
  endtask

  task automatic drain();
    while (pending_blocks.size() != 0 || cipher_results.size() != 0 || start_i)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [63:0] kv;
    fail_cnt = 0;
    cycle_cnt = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = aes_pkg::CFG_KEY_WORD_0;
    cfg_data_i = '0;
    build_sub();
    key_regs = '{default: '0};
    expand_keys();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset key (all zero), extremes of both directions
    for (int k = 0; k < 2; k++) begin
      push_block(k[0], '0, '0);
      push_block(k[0], '1, '1);
      push_block(k[0], '1, '0);
      push_block(k[0], '0, '1);
      push_block(k[0], 64'h0011223344556677, 64'h8899aabbccddeeff);
      push_block(k[0], 64'h8000000000000000, 64'h0000000000000001);
      push_block(k[0], 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    end
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      for (int i = 0; i < 4; i++) begin
        case (p)
          0: kv = '1;
          1: kv = '0;
          2: kv = 64'h0001020304050607 + 64'h0808080808080808 * i;
          default: kv = rnd64();
        endcase
        write_key(i, kv);
      end
      // from phase 3 on, a single-word change after the full key load
      if (p >= 3) write_key($urandom_range(0, 3), rnd64());
      for (int n = 0; n < PerPhase; n++) begin
        case ($urandom_range(0, 5))
          0: push_block($urandom_range(0, 1), 64'h1 << $urandom_range(0, 63),
                        ~(64'h1 << $urandom_range(0, 63)));
          1: push_block($urandom_range(0, 1), '0, '1);
          default: push_block($urandom_range(0, 1), rnd64(), rnd64());
        endcase
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("PASS aes256_block_cipher");
    end else begin
      $display("FAIL aes256_block_cipher");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/aes_pkg.sv
rtl/core/aes_key_expand.sv
rtl/core/aes_round_core.sv
rtl/core/aes256_block_cipher.sv
dv/tb.sv
